[design/prws_pkg.sv]
// Package for the particle random-walk step unit.
// Holds command codes, register indexes, reset values, CORDIC and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package prws_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int POS_FRAC_BITS_DEF     = 16;

  localparam logic [2:0] CMD_PLACE  = 3'd0;
  localparam logic [2:0] CMD_RETURN = 3'd1;
  localparam logic [2:0] CMD_RANDOM = 3'd2;
  localparam logic [2:0] CMD_OFFSET = 3'd3;
  localparam logic [2:0] CMD_MOVE   = 3'd4;

  localparam logic [1:0] REG_DIFFUSION = 2'd0;
  localparam logic [1:0] REG_TIME_STEP = 2'd1;
  localparam logic [1:0] REG_SPEED     = 2'd2;

  localparam logic [15:0] DIFFUSION_RST = 16'd256;
  localparam logic [15:0] TIME_STEP_RST = 16'd256;
  localparam logic [15:0] SPEED_RST     = 16'd0;

  localparam logic [1:0] SQ_RAD  = 2'd0;
  localparam logic [1:0] SQ_SIN  = 2'd1;
  localparam logic [1:0] SQ_NORM = 2'd2;

  // gain-corrected start value, Q2.30
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  // half of 2*pi in Q2.30; the angle product is shifted by 15 instead of 16
  localparam logic [31:0] HALF_TWO_PI_Q30 = 32'd3373259426;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd31: v = 32'd0;
      default: v = 32'd1 << (5'd30 - idx);
    endcase
    return v;
  endfunction

endpackage

[design/particle_random_walk_step.sv]
// Particle random-walk step unit: position and origin registers, one shared multiplier,
// a bit-serial square root, a CORDIC stage and a restoring divider under one sequencer.
// Depends on prws_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  in_tdata 184 bits (command word)
// out_      out  out_tvalid/out_tready out_tdata 104 bits (position word)
// cfg_      in   cfg_we               cfg_addr, cfg_wdata 16 bits
//
// Place, return, offset and unused codes go from idle straight to the output register.
// Random step: radius product, two 32-step square roots, CORDIC_ITERATIONS rotations, scaling.
// Move: norm, root, three divides, scaling; a unit or zero direction skips root and divide.
// The two bit-serial loops dominate the run time; one word is worked at a time.
// rst_n is synchronous; it clears position, origin and registers to their reset values.
// A result waits in the output register until taken; no input word is taken meanwhile.
module particle_random_walk_step #(
  parameter int CORDIC_ITERATIONS = prws_pkg::CORDIC_ITERATIONS_DEF,
  parameter int POS_FRAC_BITS     = prws_pkg::POS_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd, in_x, in_y, in_z, theta_frac, phi_frac, dir_x, dir_y, dir_z, pad
  input  wire logic [183:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, pos_z, saturated, zero_direction, pad
  output logic [103:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int RND_SH = 44 - POS_FRAC_BITS;
  localparam logic [64:0] RND_HALF = 65'd1 << (RND_SH - 1);
  localparam logic [4:0] CORD_LAST = 5'(CORDIC_ITERATIONS - 1);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_OUT     = 18'h00002,
    S_RAD_MUL = 18'h00004,
    S_RAD6    = 18'h00008,
    S_SQRT    = 18'h00010,
    S_CC_MUL  = 18'h00020,
    S_CORD_Z  = 18'h00040,
    S_CORDIC  = 18'h00080,
    S_UX_MUL  = 18'h00100,
    S_UY_MUL  = 18'h00200,
    S_UZ_SET  = 18'h00400,
    S_N2_MUL  = 18'h00800,
    S_N2_CHK  = 18'h01000,
    S_DIV_LD  = 18'h02000,
    S_DIV     = 18'h04000,
    S_LEN_MUL = 18'h08000,
    S_SCL_MUL = 18'h10000,
    S_SCL_ADD = 18'h20000
  } state_t;

  function automatic logic [32:0] sat_add(input logic signed [31:0] p,
                                          input logic signed [65:0] d);
    logic signed [65:0] s;
    s = {{34{p[31]}}, p} + d;
    if (s > 66'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (s < -66'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, s[31:0]};
  endfunction

  function automatic logic signed [31:0] round18(input logic [63:0] v, input logic neg);
    logic [63:0] m;
    m = (v + 64'd131072) >> 18;
    return neg ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  state_t state_r, state_nxt;
  logic signed [31:0] cur_r [3];
  logic signed [31:0] cur_nxt [3];
  logic signed [31:0] org_r [3];
  logic signed [31:0] org_nxt [3];
  logic [15:0] diff_r, diff_nxt, dt_r, dt_nxt, speed_r, speed_nxt;
  logic sat_r, sat_nxt, zero_r, zero_nxt;

  logic [15:0] theta_r, theta_nxt;
  logic signed [17:0] c_r, c_nxt;
  logic signed [15:0] dir_r [3];
  logic signed [15:0] dir_nxt [3];
  logic [63:0] tmp_r, tmp_nxt;
  logic [63:0] sqv_r, sqv_nxt, sqq_r, sqq_nxt, sqb_r, sqb_nxt;
  logic [1:0] sqph_r, sqph_nxt;
  logic [4:0] it_r, it_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [16:0] s_r, s_nxt;
  logic [30:0] n_r, n_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [31:0] u_r [3];
  logic signed [31:0] u_nxt [3];
  logic [30:0] rem_r, rem_nxt, quot_r, quot_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic signed [31:0] in_p [3];
  logic signed [15:0] in_d [3];
  logic [2:0] in_cmd;
  logic signed [34:0] ct_w, st_w, ct_mag, st_mag;
  logic [63:0] sq_t, sq_res;
  logic signed [33:0] cx, cy;
  logic signed [33:0] at_w;
  logic [31:0] div_r2;
  logic [64:0] rnd_sum;
  logic [64:0] rnd_m;
  logic signed [65:0] delta;
  logic [32:0] sa;
  logic [15:0] dmag;
  logic [17:0] cmag;
  logic [31:0] umag;

  assign in_cmd  = in_tdata[2:0];
  assign in_p[0] = in_tdata[34:3];
  assign in_p[1] = in_tdata[66:35];
  assign in_p[2] = in_tdata[98:67];
  assign in_d[0] = in_tdata[146:131];
  assign in_d[1] = in_tdata[162:147];
  assign in_d[2] = in_tdata[178:163];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, zero_r, sat_r, cur_r[2], cur_r[1], cur_r[0]};

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    case (theta_r[15:14])
      2'd0: begin
        ct_w = {x_r[33], x_r};
        st_w = {y_r[33], y_r};
      end
      2'd1: begin
        ct_w = -{y_r[33], y_r};
        st_w = {x_r[33], x_r};
      end
      2'd2: begin
        ct_w = -{x_r[33], x_r};
        st_w = -{y_r[33], y_r};
      end
      default: begin
        ct_w = {y_r[33], y_r};
        st_w = -{x_r[33], x_r};
      end
    endcase
    ct_mag = ct_w[34] ? -ct_w : ct_w;
    st_mag = st_w[34] ? -st_w : st_w;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    org_nxt   = org_r;
    diff_nxt  = diff_r;
    dt_nxt    = dt_r;
    speed_nxt = speed_r;
    sat_nxt   = sat_r;
    zero_nxt  = zero_r;
    theta_nxt = theta_r;
    c_nxt     = c_r;
    dir_nxt   = dir_r;
    tmp_nxt   = tmp_r;
    sqv_nxt   = sqv_r;
    sqq_nxt   = sqq_r;
    sqb_nxt   = sqb_r;
    sqph_nxt  = sqph_r;
    it_nxt    = it_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    u_nxt     = u_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    sq_t      = sqq_r + sqb_r;
    sq_res    = 64'd0;
    cx        = x_r >>> it_r;
    cy        = y_r >>> it_r;
    at_w      = $signed({2'b00, prws_pkg::atan_q30(it_r)});
    div_r2    = {rem_r, 1'b0};
    rnd_sum   = {1'b0, tmp_r} + RND_HALF;
    rnd_m     = rnd_sum >> RND_SH;
    delta     = u_r[idx_r][31] ? -$signed({1'b0, rnd_m}) : $signed({1'b0, rnd_m});
    sa        = 33'd0;
    dmag      = dir_r[idx_r][15] ? 16'(-dir_r[idx_r]) : 16'(dir_r[idx_r]);
    cmag      = c_r[17] ? 18'(-c_r) : 18'(c_r);
    umag      = u_r[idx_r][31] ? 32'(-u_r[idx_r]) : 32'(u_r[idx_r]);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          theta_nxt = in_tdata[114:99];
          c_nxt     = 18'sd65536 - $signed({1'b0, in_tdata[130:115], 1'b0});
          dir_nxt   = in_d;
          sat_nxt   = 1'b0;
          zero_nxt  = 1'b0;
          state_nxt = S_OUT;
          case (in_cmd)
            prws_pkg::CMD_PLACE: begin
              cur_nxt = in_p;
              org_nxt = in_p;
            end
            prws_pkg::CMD_RETURN: cur_nxt = org_r;
            prws_pkg::CMD_OFFSET: begin
              for (int i = 0; i < 3; i++) begin
                sa = sat_add(cur_r[i], {{34{in_p[i][31]}}, in_p[i]});
                cur_nxt[i] = sa[31:0];
                if (sa[32]) sat_nxt = 1'b1;
              end
            end
            prws_pkg::CMD_RANDOM: state_nxt = S_RAD_MUL;
            prws_pkg::CMD_MOVE: begin
              tmp_nxt   = 64'd0;
              idx_nxt   = 2'd0;
              state_nxt = S_N2_MUL;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      S_RAD_MUL: begin
        mul_a     = {16'd0, diff_r};
        mul_b     = {16'd0, dt_r};
        tmp_nxt   = mul_p;
        state_nxt = S_RAD6;
      end
      S_RAD6: begin
        mul_a     = tmp_r[31:0];
        mul_b     = 32'd6;
        sqv_nxt   = mul_p << 16;
        sqq_nxt   = 64'd0;
        sqb_nxt   = 64'd1 << 62;
        it_nxt    = 5'd0;
        sqph_nxt  = prws_pkg::SQ_RAD;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sqv_r >= sq_t) begin
          sqv_nxt = sqv_r - sq_t;
          sqq_nxt = (sqq_r >> 1) + sqb_r;
        end else begin
          sqq_nxt = sqq_r >> 1;
        end
        sqb_nxt = sqb_r >> 2;
        it_nxt  = it_r + 5'd1;
        sq_res  = sqq_nxt;
        if (it_r == 5'd31) begin
          case (sqph_r)
            prws_pkg::SQ_RAD: begin
              len_nxt   = sq_res[31:0];
              state_nxt = S_CC_MUL;
            end
            prws_pkg::SQ_SIN: begin
              s_nxt     = sq_res[16:0];
              state_nxt = S_CORD_Z;
            end
            default: begin
              n_nxt     = sq_res[30:0];
              idx_nxt   = 2'd0;
              state_nxt = S_DIV_LD;
            end
          endcase
        end
      end
      S_CC_MUL: begin
        mul_a     = {14'd0, cmag};
        mul_b     = {14'd0, cmag};
        sqv_nxt   = (64'd1 << 32) - mul_p;
        sqq_nxt   = 64'd0;
        sqb_nxt   = 64'd1 << 62;
        it_nxt    = 5'd0;
        sqph_nxt  = prws_pkg::SQ_SIN;
        state_nxt = S_SQRT;
      end
      S_CORD_Z: begin
        mul_a     = {18'd0, theta_r[13:0]};
        mul_b     = prws_pkg::HALF_TWO_PI_Q30;
        z_nxt     = $signed({2'b00, mul_p[46:15]});
        x_nxt     = prws_pkg::CORDIC_GAIN_Q30;
        y_nxt     = 34'sd0;
        it_nxt    = 5'd0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        if (!z_r[33]) begin
          x_nxt = x_r - cy;
          y_nxt = y_r + cx;
          z_nxt = z_r - at_w;
        end else begin
          x_nxt = x_r + cy;
          y_nxt = y_r - cx;
          z_nxt = z_r + at_w;
        end
        it_nxt = it_r + 5'd1;
        if (it_r == CORD_LAST) state_nxt = S_UX_MUL;
      end
      S_UX_MUL: begin
        mul_a     = {15'd0, s_r};
        mul_b     = ct_mag[31:0];
        tmp_nxt   = mul_p;
        state_nxt = S_UY_MUL;
      end
      S_UY_MUL: begin
        u_nxt[0]  = round18(tmp_r, ct_w[34]);
        mul_a     = {15'd0, s_r};
        mul_b     = st_mag[31:0];
        tmp_nxt   = mul_p;
        state_nxt = S_UZ_SET;
      end
      S_UZ_SET: begin
        u_nxt[1]  = round18(tmp_r, st_w[34]);
        u_nxt[2]  = $signed({{2{c_r[17]}}, c_r, 12'd0});
        idx_nxt   = 2'd0;
        state_nxt = S_SCL_MUL;
      end
      S_N2_MUL: begin
        mul_a   = {16'd0, dmag};
        mul_b   = {16'd0, dmag};
        tmp_nxt = tmp_r + mul_p;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) state_nxt = S_N2_CHK;
      end
      S_N2_CHK: begin
        if (tmp_r == 64'd0) begin
          zero_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else if (tmp_r == (64'd1 << 28)) begin
          for (int i = 0; i < 3; i++)
            u_nxt[i] = $signed({{2{dir_r[i][15]}}, dir_r[i], 14'd0});
          state_nxt = S_LEN_MUL;
        end else begin
          sqv_nxt   = tmp_r << 28;
          sqq_nxt   = 64'd0;
          sqb_nxt   = 64'd1 << 62;
          it_nxt    = 5'd0;
          sqph_nxt  = prws_pkg::SQ_NORM;
          state_nxt = S_SQRT;
        end
      end
      S_DIV_LD: begin
        rem_nxt   = {4'd0, dmag, 11'd0};
        quot_nxt  = 31'd0;
        it_nxt    = 5'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_r2 >= {1'b0, n_r}) begin
          rem_nxt  = 31'(div_r2 - {1'b0, n_r});
          quot_nxt = {quot_r[29:0], 1'b1};
        end else begin
          rem_nxt  = div_r2[30:0];
          quot_nxt = {quot_r[29:0], 1'b0};
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd30) begin
          u_nxt[idx_r] = dir_r[idx_r][15] ? -$signed({1'b0, quot_nxt})
                                          : $signed({1'b0, quot_nxt});
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd2) state_nxt = S_LEN_MUL;
          else state_nxt = S_DIV_LD;
        end
      end
      S_LEN_MUL: begin
        mul_a     = {16'd0, speed_r};
        mul_b     = {16'd0, dt_r};
        len_nxt   = mul_p[31:0];
        idx_nxt   = 2'd0;
        state_nxt = S_SCL_MUL;
      end
      S_SCL_MUL: begin
        mul_a     = umag;
        mul_b     = len_r;
        tmp_nxt   = mul_p;
        state_nxt = S_SCL_ADD;
      end
      S_SCL_ADD: begin
        sa = sat_add(cur_r[idx_r], delta);
        cur_nxt[idx_r] = sa[31:0];
        if (sa[32]) sat_nxt = 1'b1;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) state_nxt = S_OUT;
        else state_nxt = S_SCL_MUL;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_addr)
        prws_pkg::REG_DIFFUSION: diff_nxt  = cfg_wdata;
        prws_pkg::REG_TIME_STEP: dt_nxt    = cfg_wdata;
        prws_pkg::REG_SPEED:     speed_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= 32'sd0;
        org_r[i] <= 32'sd0;
      end
      diff_r  <= prws_pkg::DIFFUSION_RST;
      dt_r    <= prws_pkg::TIME_STEP_RST;
      speed_r <= prws_pkg::SPEED_RST;
      sat_r   <= 1'b0;
      zero_r  <= 1'b0;
      it_r    <= 5'd0;
      idx_r   <= 2'd0;
      sqph_r  <= prws_pkg::SQ_RAD;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      org_r   <= org_nxt;
      diff_r  <= diff_nxt;
      dt_r    <= dt_nxt;
      speed_r <= speed_nxt;
      sat_r   <= sat_nxt;
      zero_r  <= zero_nxt;
      it_r    <= it_nxt;
      idx_r   <= idx_nxt;
      sqph_r  <= sqph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    theta_r <= theta_nxt;
    c_r     <= c_nxt;
    dir_r   <= dir_nxt;
    tmp_r   <= tmp_nxt;
    sqv_r   <= sqv_nxt;
    sqq_r   <= sqq_nxt;
    sqb_r   <= sqb_nxt;
    len_r   <= len_nxt;
    s_r     <= s_nxt;
    n_r     <= n_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    u_r     <= u_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
  end

endmodule

`default_nettype wire
